// ----- rtl/bcr_pkg.sv -----
`default_nettype none

package bcr_pkg;

  typedef logic signed [31:0] q16_t;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_COEF_3    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COEF_2    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COEF_1    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COEF_0    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TOLERANCE = 3'd4;

  localparam logic [31:0] TOL_RESET = 32'd66;
  localparam q16_t        SAT_MAX   = 32'sh7fff_ffff;
  localparam q16_t        SAT_MIN   = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL_LO,
    ST_CHECK,
    ST_EVAL_MID,
    ST_DONE
  } bcr_state_e;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MUL,
    HS_ADD
  } hrn_state_e;

  typedef struct packed {
    logic start;
    q16_t x;
  } hrn_req_t;

  typedef struct packed {
    logic done;
    q16_t value;
  } hrn_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/bcr_horner.sv -----
`default_nettype none

// Evaluates the cubic by Horner's rule on one multiplier and one adder,
// with a multiply state and then a saturating add state for each term.
module bcr_horner (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bcr_pkg::q16_t     coef_i [4],
  input  wire bcr_pkg::hrn_req_t req_i,
  output bcr_pkg::hrn_rsp_t      rsp_o
);

  bcr_pkg::hrn_state_e state_q, state_d;
  logic [1:0]          idx_q;
  logic                done_q;
  bcr_pkg::q16_t       acc_q;
  bcr_pkg::q16_t       x_q;
  logic signed [63:0]  prod_q;

  logic signed [47:0]  shr;
  bcr_pkg::q16_t       mul_sat;
  logic signed [32:0]  sum;
  bcr_pkg::q16_t       add_sat;

  always_comb begin
    shr = prod_q[63:16];
    if (!shr[47] && (|shr[46:31])) begin
      mul_sat = bcr_pkg::SAT_MAX;
    end else if (shr[47] && !(&shr[46:31])) begin
      mul_sat = bcr_pkg::SAT_MIN;
    end else begin
      mul_sat = shr[31:0];
    end
    sum = {mul_sat[31], mul_sat} + {coef_i[idx_q][31], coef_i[idx_q]};
    if (sum[32] != sum[31]) begin
      add_sat = sum[32] ? bcr_pkg::SAT_MIN : bcr_pkg::SAT_MAX;
    end else begin
      add_sat = sum[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bcr_pkg::HS_IDLE: begin
        if (req_i.start) begin
          state_d = bcr_pkg::HS_MUL;
        end
      end
      bcr_pkg::HS_MUL: begin
        state_d = bcr_pkg::HS_ADD;
      end
      bcr_pkg::HS_ADD: begin
        state_d = (idx_q == 2'd0) ? bcr_pkg::HS_IDLE : bcr_pkg::HS_MUL;
      end
      default: begin
        state_d = bcr_pkg::HS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcr_pkg::HS_IDLE;
      idx_q   <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == bcr_pkg::HS_ADD) && (idx_q == 2'd0);
      if (state_q == bcr_pkg::HS_IDLE && req_i.start) begin
        idx_q <= 2'd2;
      end else if (state_q == bcr_pkg::HS_ADD && idx_q != 2'd0) begin
        idx_q <= idx_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bcr_pkg::HS_IDLE && req_i.start) begin
      acc_q <= coef_i[3];
      x_q   <= req_i.x;
    end else if (state_q == bcr_pkg::HS_MUL) begin
      prod_q <= acc_q * x_q;
    end else if (state_q == bcr_pkg::HS_ADD) begin
      acc_q <= add_sat;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = acc_q;

endmodule

`default_nettype wire

// ----- rtl/bisection_cubic_root.sv -----
// Bisection root finder for the cubic coef_3*x^3 + coef_2*x^2 + coef_1*x + coef_0
// in signed Q16.16. The configuration channel writes one register per beat
// (index 0..4: coef_3, coef_2, coef_1, coef_0, tolerance); it is always ready
// and should be used only while the block is idle. Each input beat carries
// the interval ends, low in tdata[31:0] and high in tdata[63:32]; each
// output beat carries the root, the midpoint of the final interval.
// Sequence: after the start, p(low) is evaluated once; each bisection step
// is then one check plus an evaluation of p(mid) (three multiply and add
// pairs and one result register on the shared Horner unit), for at most
// MAX_STEPS steps (48 by default), followed by the final check and the load
// of the output register. The search ends early when a midpoint value is zero.
// One item is in progress at a time; the input is ready only while idle.
// The result sits in an output register; a new item may be accepted while
// it waits, and that item stalls at its end until the receiver takes the
// previous result. Reset clears all control state, sets the coefficients
// to zero and the tolerance to 66 (about 0.001).
`default_nettype none

module bisection_cubic_root #(
  parameter int unsigned MAX_STEPS = 48
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bcr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // interval_low [31:0], interval_high [63:32]
  input  wire logic [63:0]                 s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // root [31:0]
  output logic [31:0]                      m_axis_tdata_o
);

  localparam int unsigned StepW = $clog2(MAX_STEPS + 1);

  bcr_pkg::bcr_state_e state_q, state_d;
  bcr_pkg::q16_t       coef_q [4];
  logic [31:0]         tol_q;
  bcr_pkg::q16_t       lo_q;
  bcr_pkg::q16_t       hi_q;
  bcr_pkg::q16_t       mid_q;
  logic [StepW-1:0]    steps_q;
  logic                vl_neg_q;
  logic                vl_pos_q;
  logic                out_valid_q;
  logic [31:0]         out_data_q;

  bcr_pkg::hrn_req_t   hreq;
  bcr_pkg::hrn_rsp_t   hrsp;

  logic                in_fire;
  logic                out_free;
  logic signed [33:0]  width;
  logic signed [32:0]  sum;
  bcr_pkg::q16_t       mid;
  logic                cont;
  logic                vm_zero;
  logic                vm_neg;
  logic                vm_pos;
  logic                flip;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == bcr_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign width = {{2{hi_q[31]}}, hi_q} - {{2{lo_q[31]}}, lo_q};
  assign sum   = {hi_q[31], hi_q} + {lo_q[31], lo_q};
  assign mid   = sum[32:1];
  assign cont  = (steps_q < StepW'(MAX_STEPS)) && (width > $signed({2'b00, tol_q}));

  assign vm_zero = (hrsp.value == '0);
  assign vm_neg  = hrsp.value[31];
  assign vm_pos  = !vm_neg && !vm_zero;
  assign flip    = (vl_neg_q && vm_pos) || (vl_pos_q && vm_neg);

  always_comb begin
    hreq.start = 1'b0;
    hreq.x     = mid;
    if (state_q == bcr_pkg::ST_IDLE) begin
      hreq.start = in_fire;
      hreq.x     = s_axis_tdata_i[31:0];
    end else if (state_q == bcr_pkg::ST_CHECK) begin
      hreq.start = cont;
    end
  end

  bcr_horner u_horner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_q),
    .req_i  (hreq),
    .rsp_o  (hrsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      bcr_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = bcr_pkg::ST_EVAL_LO;
        end
      end
      bcr_pkg::ST_EVAL_LO: begin
        if (hrsp.done) begin
          state_d = bcr_pkg::ST_CHECK;
        end
      end
      bcr_pkg::ST_CHECK: begin
        state_d = cont ? bcr_pkg::ST_EVAL_MID : bcr_pkg::ST_DONE;
      end
      bcr_pkg::ST_EVAL_MID: begin
        if (hrsp.done) begin
          state_d = vm_zero ? bcr_pkg::ST_DONE : bcr_pkg::ST_CHECK;
        end
      end
      bcr_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = bcr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bcr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcr_pkg::ST_IDLE;
      coef_q[0]   <= '0;
      coef_q[1]   <= '0;
      coef_q[2]   <= '0;
      coef_q[3]   <= '0;
      tol_q       <= bcr_pkg::TOL_RESET;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bcr_pkg::REG_COEF_3:    coef_q[3] <= cfg_data_i;
          bcr_pkg::REG_COEF_2:    coef_q[2] <= cfg_data_i;
          bcr_pkg::REG_COEF_1:    coef_q[1] <= cfg_data_i;
          bcr_pkg::REG_COEF_0:    coef_q[0] <= cfg_data_i;
          bcr_pkg::REG_TOLERANCE: tol_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        steps_q <= '0;
      end else if (state_q == bcr_pkg::ST_CHECK && cont) begin
        steps_q <= steps_q + StepW'(1);
      end
      if (state_q == bcr_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lo_q <= s_axis_tdata_i[31:0];
      hi_q <= s_axis_tdata_i[63:32];
    end
    if (state_q == bcr_pkg::ST_CHECK) begin
      mid_q <= mid;
    end
    if (state_q == bcr_pkg::ST_EVAL_LO && hrsp.done) begin
      vl_neg_q <= vm_neg;
      vl_pos_q <= vm_pos;
    end
    if (state_q == bcr_pkg::ST_EVAL_MID && hrsp.done && !vm_zero) begin
      if (flip) begin
        hi_q <= mid_q;
      end else begin
        lo_q     <= mid_q;
        vl_neg_q <= vm_neg;
        vl_pos_q <= vm_pos;
      end
    end
    if (state_q == bcr_pkg::ST_DONE && out_free) begin
      out_data_q <= mid_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_done_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hrsp.done |-> (state_q == bcr_pkg::ST_EVAL_LO || state_q == bcr_pkg::ST_EVAL_MID))
    else $error("Horner result outside an evaluation state");

  a_step_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= StepW'(MAX_STEPS))
    else $error("Step count above the cap");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == bcr_pkg::ST_EVAL_LO)
    else $error("Accepted beat did not start an evaluation");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcr_pkg::ST_DONE && out_valid_q && !m_axis_tready_i)
      |=> state_q == bcr_pkg::ST_DONE)
    else $error("Result left while the output register was full");
`endif

endmodule

`default_nettype wire
